FILE: rtl/core/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared constants, register indexes and types of the parameterised
// Mersenne Twister word generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pmt_pkg;

  // State store geometry.
  localparam int unsigned STATE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(STATE_DEPTH);
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned MID_W       = 10;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CFG_IDX_W   = 4;

  // Tempering shifts.
  localparam int unsigned SHIFT_FIRST = 11;
  localparam int unsigned SHIFT_B     = 7;
  localparam int unsigned SHIFT_C     = 15;
  localparam int unsigned SHIFT_LAST  = 18;

  // Seeding recurrence.
  localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
  localparam int unsigned       SEED_SHIFT = 30;

  // Register reset values.
  localparam logic [LEN_W-1:0]  RST_WORDS   = 11'd624;
  localparam logic [MID_W-1:0]  RST_MIDDLE  = 10'd397;
  localparam logic [WORD_W-1:0] RST_MATRIX  = 32'h9908B0DF;
  localparam logic [WORD_W-1:0] RST_UPPER   = 32'h80000000;
  localparam logic [WORD_W-1:0] RST_LOWER   = 32'h7FFFFFFF;
  localparam logic [WORD_W-1:0] RST_WMASK   = 32'hFFFFFFFF;
  localparam logic [WORD_W-1:0] RST_TMASK_B = 32'h9D2C5680;
  localparam logic [WORD_W-1:0] RST_TMASK_C = 32'hEFC60000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORDS   = 4'd0,
    REG_MIDDLE  = 4'd1,
    REG_MATRIX  = 4'd2,
    REG_UPPER   = 4'd3,
    REG_LOWER   = 4'd4,
    REG_WMASK   = 4'd5,
    REG_TMASK_B = 4'd6,
    REG_TMASK_C = 4'd7
  } cfg_reg_e;

  // Input request kinds.
  localparam logic ACT_SEED = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  // Tempering masks handed to the tempering unit.
  typedef struct packed {
    logic [WORD_W-1:0] mask_b;
    logic [WORD_W-1:0] mask_c;
  } temper_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/param_mersenne_twister.sv
// ----------------------------------------------------------------------------
// param_mersenne_twister
// Parameterised Mersenne Twister word generator with a 1024-word state store.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request per handshake. tuser = action (0 seed, 1 draw),
//   tdata = seed_value. A seed fills the words in use and gives no result;
//   a draw gives one tempered word on m_axis.
//   cfg: register writes (index, data), always ready; write only while idle.
// Sequence:
//   A draw reads the store and registers the tempered word for the output.
//   A draw that finds the state spent first twists all words in use through
//   the store's single read port (read next word, read far word, write).
//   A seed writes the first word at once, then computes and writes the rest.
//   The next request is taken once the result has been handed over.
// Reset:
//   Configuration and control registers return to their reset values and a
//   clearing pass writes zero to all 1024 store words, one per cycle;
//   s_axis_tready stays low during the pass.
// Stall:
//   A result waits in the output register until m_axis_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module param_mersenne_twister (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Requests. tdata: seed_value[31:0]. tuser: action[0].
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [pmt_pkg::WORD_W-1:0]    s_axis_tdata,
  input  wire logic                          s_axis_tuser,
  // Results. tdata: random_word[31:0].
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [pmt_pkg::WORD_W-1:0]    m_axis_tdata,
  // Configuration writes.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pmt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [pmt_pkg::WORD_W-1:0]    cfg_data_i
);
  import pmt_pkg::*;

  typedef enum logic [10:0] {
    ST_CLR    = 11'b000_0000_0001,
    ST_IDLE   = 11'b000_0000_0010,
    ST_SD_MUL = 11'b000_0000_0100,
    ST_SD_WR  = 11'b000_0000_1000,
    ST_TW_RD0 = 11'b000_0001_0000,
    ST_TW_LD0 = 11'b000_0010_0000,
    ST_TW_NXT = 11'b000_0100_0000,
    ST_TW_FAR = 11'b000_1000_0000,
    ST_TW_WR  = 11'b001_0000_0000,
    ST_DR_RD  = 11'b010_0000_0000,
    ST_DR_OUT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [LEN_W-1:0]  words_q;
  logic [MID_W-1:0]  middle_q;
  logic [WORD_W-1:0] matrix_q, upper_q, lower_q, wmask_q;
  temper_cfg_t       tcfg_q;

  // Working registers.
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  ridx_q, ridx_d;
  logic [WORD_W-1:0] prev_q, prev_d;
  logic [WORD_W-1:0] prod_q, prod_d;
  logic [WORD_W-1:0] cur_q, cur_d;
  logic [WORD_W-1:0] nxt_q, nxt_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_data_q, out_data_d;

  // Memory port signals.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  logic [LEN_W-1:0]  len_n, mid_m, nxt_idx, far_idx;
  logic [LEN_W:0]    far_sum;
  logic [WORD_W-1:0] seed_word, twist_x, twist_word, tempered;
  logic              in_req;

  // Configuration port: always ready, unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q       <= RST_WORDS;
      middle_q      <= RST_MIDDLE;
      matrix_q      <= RST_MATRIX;
      upper_q       <= RST_UPPER;
      lower_q       <= RST_LOWER;
      wmask_q       <= RST_WMASK;
      tcfg_q.mask_b <= RST_TMASK_B;
      tcfg_q.mask_c <= RST_TMASK_C;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WORDS:   words_q       <= cfg_data_i[LEN_W-1:0];
        REG_MIDDLE:  middle_q      <= cfg_data_i[MID_W-1:0];
        REG_MATRIX:  matrix_q      <= cfg_data_i;
        REG_UPPER:   upper_q       <= cfg_data_i;
        REG_LOWER:   lower_q       <= cfg_data_i;
        REG_WMASK:   wmask_q       <= cfg_data_i;
        REG_TMASK_B: tcfg_q.mask_b <= cfg_data_i;
        REG_TMASK_C: tcfg_q.mask_c <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Length and middle offset, clamped to their legal ranges.
  always_comb begin
    if (words_q < LEN_W'(2)) begin
      len_n = LEN_W'(2);
    end else if (words_q > LEN_W'(STATE_DEPTH)) begin
      len_n = LEN_W'(STATE_DEPTH);
    end else begin
      len_n = words_q;
    end
    if (middle_q == '0) begin
      mid_m = LEN_W'(1);
    end else begin
      mid_m = LEN_W'(middle_q);
    end
    if (mid_m > len_n - LEN_W'(1)) begin
      mid_m = len_n - LEN_W'(1);
    end
  end

  // Twist neighbor indexes, wrapped at the length in use.
  always_comb begin
    nxt_idx = (cnt_q + LEN_W'(1) < len_n) ? cnt_q + LEN_W'(1) : '0;
    far_sum = {1'b0, cnt_q} + {1'b0, mid_m};
    if (far_sum >= {1'b0, len_n}) begin
      far_sum = far_sum - {1'b0, len_n};
    end
    far_idx = far_sum[LEN_W-1:0];
  end

  // Twist of one word: current, next and far word from the store.
  always_comb begin
    twist_x    = (cur_q & upper_q) | (nxt_q & lower_q);
    twist_word = mem_rdata ^ (twist_x >> 1) ^ (twist_x[0] ? matrix_q : '0);
  end

  assign seed_word = (prod_q + WORD_W'(cnt_q)) & wmask_q;

  assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
  assign in_req        = s_axis_tvalid && s_axis_tready;

  // Sequencer and memory port control.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ridx_d      = ridx_q;
    prev_d      = prev_q;
    prod_d      = prod_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[ADDR_W-1:0];
    mem_wdata   = twist_word;
    mem_raddr   = '0;

    case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        cnt_d     = cnt_q + LEN_W'(1);
        if (cnt_q[ADDR_W-1:0] == ADDR_W'(STATE_DEPTH - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_req) begin
          if (s_axis_tuser == ACT_SEED) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = s_axis_tdata & wmask_q;
            prev_d    = s_axis_tdata & wmask_q;
            cnt_d     = LEN_W'(1);
            state_d   = ST_SD_MUL;
          end else if (ridx_q >= len_n) begin
            cnt_d   = '0;
            state_d = ST_TW_RD0;
          end else begin
            state_d = ST_DR_RD;
          end
        end
      end
      ST_SD_MUL: begin
        prod_d  = SEED_MULT * (prev_q ^ (prev_q >> SEED_SHIFT));
        state_d = ST_SD_WR;
      end
      ST_SD_WR: begin
        mem_we    = 1'b1;
        mem_wdata = seed_word;
        prev_d    = seed_word;
        if (cnt_q == len_n - LEN_W'(1)) begin
          ridx_d  = len_n;
          state_d = ST_IDLE;
        end else begin
          cnt_d   = cnt_q + LEN_W'(1);
          state_d = ST_SD_MUL;
        end
      end
      ST_TW_RD0: begin
        mem_raddr = '0;
        state_d   = ST_TW_LD0;
      end
      ST_TW_LD0: begin
        cur_d   = mem_rdata;
        state_d = ST_TW_NXT;
      end
      ST_TW_NXT: begin
        mem_raddr = nxt_idx[ADDR_W-1:0];
        state_d   = ST_TW_FAR;
      end
      ST_TW_FAR: begin
        nxt_d     = mem_rdata;
        mem_raddr = far_idx[ADDR_W-1:0];
        state_d   = ST_TW_WR;
      end
      ST_TW_WR: begin
        mem_we = 1'b1;
        cur_d  = nxt_q;
        if (cnt_q == len_n - LEN_W'(1)) begin
          ridx_d  = '0;
          state_d = ST_DR_RD;
        end else begin
          cnt_d   = cnt_q + LEN_W'(1);
          state_d = ST_TW_NXT;
        end
      end
      ST_DR_RD: begin
        mem_raddr = ridx_q[ADDR_W-1:0];
        state_d   = ST_DR_OUT;
      end
      ST_DR_OUT: begin
        out_valid_d = 1'b1;
        out_data_d  = tempered;
        ridx_d      = ridx_q + LEN_W'(1);
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_CLR;
        cnt_d   = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      ridx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ridx_q      <= ridx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    prod_q     <= prod_d;
    cur_q      <= cur_d;
    nxt_q      <= nxt_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  pmt_ram #(
    .Width (WORD_W),
    .Depth (STATE_DEPTH)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pmt_temper u_temper (
    .word_i (mem_rdata),
    .cfg_i  (tcfg_q),
    .word_o (tempered)
  );

  // A result appears only after the store read of a draw.
  a_out_from_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DR_OUT))
    else $error("result raised outside a draw");

  // No request is taken during the clearing pass.
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !s_axis_tready)
    else $error("request accepted while clearing the store");

  // The far word of a twist step is never the word being rewritten.
  a_far_not_self: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TW_FAR) |-> (far_idx != cnt_q))
    else $error("twist far index equals current index");

  // A draw that finds the state spent always starts a twist.
  a_spent_twists: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req && s_axis_tuser == ACT_DRAW && ridx_q >= len_n) |=> (state_q == ST_TW_RD0))
    else $error("spent state not regenerated");

endmodule

`default_nettype wire

FILE: rtl/core/pmt_ram.sv
// ----------------------------------------------------------------------------
// pmt_ram
// Generic simple dual-port RAM: one write port, one read port and
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/pmt_temper.sv
// ----------------------------------------------------------------------------
// pmt_temper
// Output tempering: two right-shift and two masked left-shift xor steps.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_temper (
  input  wire logic [pmt_pkg::WORD_W-1:0] word_i,
  input  wire pmt_pkg::temper_cfg_t       cfg_i,
  output logic      [pmt_pkg::WORD_W-1:0] word_o
);
  import pmt_pkg::*;

  logic [WORD_W-1:0] step1;
  logic [WORD_W-1:0] step2;
  logic [WORD_W-1:0] step3;

  // Four tempering steps in a row.
  always_comb begin
    step1  = word_i ^ (word_i >> SHIFT_FIRST);
    step2  = step1 ^ ((step1 << SHIFT_B) & cfg_i.mask_b);
    step3  = step2 ^ ((step2 << SHIFT_C) & cfg_i.mask_c);
    word_o = step3 ^ (step3 >> SHIFT_LAST);
  end

endmodule

`default_nettype wire

FILE: dv/param_mersenne_twister_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// param_mersenne_twister_test
// Self-checking bench for the parameterised Mersenne Twister generator. Seed
// and draw requests are streamed in under several register settings and
// random back pressure. Every returned word is compared with a cycle-free
// prediction of the state store, twist and tempering.
// ----------------------------------------------------------------------------
`default_nettype none

module param_mersenne_twister_test;
  import pmt_pkg::*;

  localparam int unsigned WATCH_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT  = 3200;

  // Prediction of the generator and store of the words still owed by it.
  class twister_scoreboard;
    logic [LEN_W-1:0]  words_in_use;
    logic [MID_W-1:0]  middle_offset;
    logic [WORD_W-1:0] matrix, upper, lower, wmask, tmask_b, tmask_c;
    logic [WORD_W-1:0] store [STATE_DEPTH];
    int unsigned       rd_index;
    logic [WORD_W-1:0] owed_words [$];
    int unsigned       fails, words_checked, seeds_seen, twists_seen;

    function new();
      words_in_use  = RST_WORDS;
      middle_offset = RST_MIDDLE;
      matrix        = RST_MATRIX;
      upper         = RST_UPPER;
      lower         = RST_LOWER;
      wmask         = RST_WMASK;
      tmask_b       = RST_TMASK_B;
      tmask_c       = RST_TMASK_C;
      foreach (store[k]) store[k] = '0;
      rd_index = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_WORDS:   words_in_use  = data[LEN_W-1:0];
        REG_MIDDLE:  middle_offset = data[MID_W-1:0];
        REG_MATRIX:  matrix        = data;
        REG_UPPER:   upper         = data;
        REG_LOWER:   lower         = data;
        REG_WMASK:   wmask         = data;
        REG_TMASK_B: tmask_b       = data;
        REG_TMASK_C: tmask_c       = data;
        default: ;
      endcase
    endfunction

    // Length in use, clamped to at least 2 and to the store depth.
    function int unsigned span();
      int unsigned n;
      n = words_in_use;
      if (n < 2) n = 2;
      if (n > STATE_DEPTH) n = STATE_DEPTH;
      return n;
    endfunction

    // Regenerate all words in use, in place and with wrapping indexes.
    function void twist(int unsigned n);
      int unsigned mid, nxt, far;
      logic [WORD_W-1:0] x;
      mid = middle_offset;
      if (mid < 1) mid = 1;
      if (mid > n - 1) mid = n - 1;
      for (int unsigned k = 0; k < n; k++) begin
        nxt = (k + 1 < n) ? k + 1 : 0;
        far = k + mid;
        if (far >= n) far -= n;
        x = (store[k] & upper) | (store[nxt] & lower);
        store[k] = store[far] ^ (x >> 1) ^ (x[0] ? matrix : '0);
      end
      twists_seen++;
    endfunction

    function logic [WORD_W-1:0] temper(logic [WORD_W-1:0] v);
      v ^= v >> SHIFT_FIRST;
      v ^= (v << SHIFT_B) & tmask_b;
      v ^= (v << SHIFT_C) & tmask_c;
      v ^= v >> SHIFT_LAST;
      return v;
    endfunction

    // Note an accepted request and, for a draw, queue the word it will produce.
    function void note_request(logic action, logic [WORD_W-1:0] seed);
      int unsigned n;
      logic [WORD_W-1:0] p;
      n = span();
      if (action == ACT_SEED) begin
        store[0] = seed & wmask;
        for (int unsigned i = 1; i < n; i++) begin
          p = store[i-1];
          store[i] = (SEED_MULT * (p ^ (p >> SEED_SHIFT)) + WORD_W'(i)) & wmask;
        end
        rd_index = n;
        seeds_seen++;
      end else begin
        if (rd_index >= n) begin
          twist(n);
          rd_index = 0;
        end
        owed_words.push_back(temper(store[rd_index]));
        rd_index++;
      end
    endfunction

    function void check_word(logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (owed_words.size() == 0) begin
        $error("random_word: no result expected, actual %h", got);
        fails++;
        return;
      end
      want = owed_words.pop_front();
      words_checked++;
      if (got !== want) begin
        $error("random_word: expected %h, actual %h", want, got);
        fails++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [WORD_W-1:0]    s_axis_tdata = '0;
  logic                 s_axis_tuser = ACT_DRAW;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [WORD_W-1:0]    m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_WORDS;
  logic [WORD_W-1:0]    cfg_data_i = '0;

  twister_scoreboard twister_sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request  = 0;
  int unsigned requests_sent = 0;

  param_mersenne_twister DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random ready, with an occasional long hold-off.
  initial begin
    int unsigned hold;
    forever begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  // Check each accepted result.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) twister_sb.check_word(m_axis_tdata);
  end

  // Watchdog on cycles without any accepted request, result or register write.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
      if (quiet >= WATCH_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one request, after an optional gap, and wait for its handshake.
  task automatic send_request(logic action, logic [WORD_W-1:0] seed);
    int unsigned gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= seed;
    do @(posedge clk_i); while (!s_axis_tready);
    twister_sb.note_request(action, seed);
    requests_sent++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [WORD_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    twister_sb.write_reg(idx, data);
  endtask

  task automatic write_raw(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    twister_sb.write_reg(idx, data);
  endtask

  // Drop the request line, collect all owed words, then let a trailing seed finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (twister_sb.owed_words.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_all(logic [WORD_W-1:0] words, logic [WORD_W-1:0] mid,
                           logic [WORD_W-1:0] mat, logic [WORD_W-1:0] up,
                           logic [WORD_W-1:0] lo, logic [WORD_W-1:0] wm,
                           logic [WORD_W-1:0] tb, logic [WORD_W-1:0] tc);
    write_reg(REG_WORDS, words);
    write_reg(REG_MIDDLE, mid);
    write_reg(REG_MATRIX, mat);
    write_reg(REG_UPPER, up);
    write_reg(REG_LOWER, lo);
    write_reg(REG_WMASK, wm);
    write_reg(REG_TMASK_B, tb);
    write_reg(REG_TMASK_C, tc);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned n, sel;
    logic [WORD_W-1:0] wm;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: draws from the cleared store, then extreme seeds at reset settings.
    send_idle_pct = 26;
    recv_idle_pct = 73;
    repeat (3) send_request(ACT_DRAW, $urandom());
    send_request(ACT_SEED, '0);
    repeat (2) send_request(ACT_DRAW, '1);
    send_request(ACT_SEED, '1);
    repeat (3) send_request(ACT_DRAW, '0);
    settle();

    // Length below the minimum, middle offset of zero, extreme masks.
    write_all(32'd1, 32'd0, '1, '0, '1, '1, '0, '0);
    send_request(ACT_SEED, 32'h1234_5678);
    repeat (4) send_request(ACT_DRAW, '0);
    settle();

    // Oversize length from unused bits, middle at its top, unknown indexes ignored.
    write_all('1, '1, '0, '1, '0, 32'h0000_FFFF, '1, '1);
    for (int i = 8; i < 16; i++) write_raw(i[CFG_IDX_W-1:0], $urandom());
    cfg_valid_i <= 1'b0;
    send_request(ACT_SEED, 32'hA5A5_5A5A);
    repeat (3) send_request(ACT_DRAW, '0);
    settle();

    // Middle offset above the length, then the length lowered below the read index.
    write_all(32'd40, 32'd900, RST_MATRIX, RST_UPPER, RST_LOWER, RST_WMASK,
              RST_TMASK_B, RST_TMASK_C);
    send_request(ACT_SEED, 32'd5489);
    repeat (30) send_request(ACT_DRAW, '0);
    settle();
    write_reg(REG_WORDS, 32'd8);
    cfg_valid_i <= 1'b0;
    repeat (10) send_request(ACT_DRAW, '0);
    settle();

    // Random phases: mostly short state lengths, a few full-size ones.
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 73 : 0;
      recv_idle_pct = (ph < 2) ? 73 : (ph < 4) ? 26 : 0;
      sel = $urandom_range(9);
      n   = (sel == 0) ? STATE_DEPTH : (sel == 1) ? $urandom_range(0, 1) :
            $urandom_range(2, 40);
      wm  = ($urandom_range(2) == 0) ? $urandom() : '1;
      write_all(n, $urandom_range(0, n + 3), $urandom(), $urandom(), $urandom(),
                wm, $urandom(), $urandom());
      if (ph == 3) hold_request = 400;
      for (int k = 0; k < 105; k++) begin
        if ($urandom_range(99) < 8) send_request(ACT_SEED, $urandom());
        else send_request(ACT_DRAW, $urandom());
      end
      settle();
    end

    if (twister_sb.owed_words.size() != 0) twister_sb.fails++;
    $display("Run covered %0d requests, %0d seeds, %0d twists, %0d words checked.",
             requests_sent, twister_sb.seeds_seen, twister_sb.twists_seen,
             twister_sb.words_checked);
    if (twister_sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/pmt_pkg.sv
rtl/core/pmt_ram.sv
rtl/core/pmt_temper.sv
rtl/core/param_mersenne_twister.sv
dv/param_mersenne_twister_test.sv
